// File: sv/crr_pkg.sv
// shared types and constants for the catmull-rom curve resampler
`timescale 1ns / 1ps
package crr_pkg;

    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_PPS = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COEF,
        ST_MUL,
        ST_ACC,
        ST_SAT,
        ST_OUT
    } crr_state_t;

endpackage

// File: sv/catmull_rom_curve_resampler_top.sv
// catmull-rom curve resampler top level
// each sample evaluates x, y and z in turn (coef, mul and acc states per axis), then the output state
// a segment holds k samples; a middle point gives at most one segment, a last point up to two
// not ready while a point is resampled; a waiting word stalls only the output state
// reset: async active low, clears window, point count, and sets k to 8
`timescale 1ns / 1ps
module catmull_rom_curve_resampler_top #(
    parameter int MAX_SAMPLES_PER_SEGMENT = 16,
    parameter int COORD_WIDTH = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [crr_pkg::CFG_ADDR_W+1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] point_x,
    input  logic signed [COORD_WIDTH-1:0] point_y,
    input  logic signed [COORD_WIDTH-1:0] point_z,
    input  logic                          last_point,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] curve_x,
    output logic signed [COORD_WIDTH-1:0] curve_y,
    output logic signed [COORD_WIDTH-1:0] curve_z,
    output logic                          last_sample
);
    import crr_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int FB = FRACTION_BITS;
    localparam int AW = CW + 8;
    localparam int KW = $clog2(MAX_SAMPLES_PER_SEGMENT + 1);
    localparam int MS = MAX_SAMPLES_PER_SEGMENT;

    logic [4:0]           pps_reg;
    logic signed [CW-1:0] win_reg [3][3];
    logic [1:0]           seen_reg;
    crr_state_t           st_reg, st_next;
    logic                 last_reg;
    logic signed [CW-1:0] pin_reg [3];
    logic                 seg_reg;
    logic                 two_reg;
    logic [1:0]           ax_reg;
    logic [KW-1:0]        j_reg;
    logic [KW-1:0]        k_reg;
    logic [FB:0]          step_reg;
    logic [FB:0]          t_reg;
    logic signed [AW-1:0] ca_reg, cb_reg, cc_reg, cd_reg;
    logic [CW-1:0]        res_reg [3];
    logic                 ov_reg;
    logic                 ls_reg;
    logic                 ev_start;
    logic                 ev_done;
    logic [CW-1:0]        ev_res;
    logic                 accept;
    logic [KW-1:0]        k_eff;
    logic [FB:0]          step_q;
    logic [FB:0]          step_tab [1:MS];
    logic signed [AW-1:0] p0, p1, p2, p3, ta, tb, tc, q0, q1, s0, s1;

    assign pready = 1'b1;
    assign prdata = (paddr[CFG_ADDR_W+1:2] == REG_PPS) ? {27'd0, pps_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pps_reg <= 5'd8;
        else if (psel && penable && pwrite && paddr[CFG_ADDR_W+1:2] == REG_PPS)
            pps_reg <= pwdata[4:0];
    end

    always_comb
    begin
        if (pps_reg == 5'd0)
            k_eff = KW'(1);
        else if (32'(pps_reg) > MS)
            k_eff = KW'(MS);
        else
            k_eff = KW'(pps_reg);
    end

    // step = floor(2^fb / k), small table over k
    for (genvar g = 1; g <= MS; g++)
    begin : g_step
        localparam logic [FB:0] STEP = (FB+1)'((1 << FB) / g);
        assign step_tab[g] = STEP;
    end

    always_comb
    begin
        step_q = '0;
        for (int i = 1; i <= MS; i++)
            if (k_eff == KW'(i))
                step_q = step_tab[i];
    end

    assign in_ready = (st_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // coefficients for the current axis and segment
    always_comb
    begin
        p0 = AW'(win_reg[0][ax_reg]);
        p1 = AW'(win_reg[1][ax_reg]);
        p2 = AW'(win_reg[2][ax_reg]);
        p3 = AW'(pin_reg[ax_reg]);
        tc = p3 - p2;
        tb = (p3 - p1) >>> 1;
        ta = (seen_reg == 2'd2) ? (p2 - p1) : ((p2 - p0) >>> 1);
        if (seen_reg == 2'd1)
        begin
            q0 = p2; q1 = p3; s0 = tc; s1 = tc;
        end
        else if (!seg_reg)
        begin
            q0 = p1; q1 = p2; s0 = ta; s1 = tb;
        end
        else
        begin
            q0 = p2; q1 = p3; s0 = tb; s1 = tc;
        end
    end

    crr_eval #(.CW(CW), .FB(FB), .AW(AW)) u_eval (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ev_start),
        .coef_a (ca_reg),
        .coef_b (cb_reg),
        .coef_c (cc_reg),
        .coef_d (cd_reg),
        .t      (t_reg),
        .done   (ev_done),
        .result (ev_res)
    );

    logic seg_end, all_end;
    assign seg_end = (j_reg == k_reg - KW'(1));
    assign all_end = seg_end && (!two_reg || seg_reg);

    always_comb
    begin
        st_next  = st_reg;
        ev_start = 1'b0;
        unique case (st_reg)
            ST_IDLE:
                if (accept)
                begin
                    if (seen_reg == 2'd0 || (seen_reg == 2'd1 && !last_point))
                        st_next = ST_SAT;
                    else
                        st_next = ST_COEF;
                end
            ST_COEF:
                st_next = ST_MUL;
            ST_MUL:
            begin
                ev_start = 1'b1;
                st_next  = ST_ACC;
            end
            ST_ACC:
                if (ev_done)
                begin
                    if (ax_reg == 2'd2)
                        st_next = ST_OUT;
                    else
                        st_next = ST_COEF;
                end
            ST_OUT:
                if (!ov_reg || out_ready)
                    st_next = all_end ? ST_SAT : ST_COEF;
            ST_SAT:
                st_next = ST_IDLE;
            default:
                st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            seen_reg <= '0;
            ov_reg   <= 1'b0;
            for (int i = 0; i < 3; i++)
                for (int a = 0; a < 3; a++)
                    win_reg[i][a] <= '0;
        end
        else
        begin
            st_reg <= st_next;
            if (st_reg == ST_OUT && (!ov_reg || out_ready))
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
            // window update once the point is done
            if (st_reg == ST_SAT)
            begin
                if (last_reg)
                begin
                    seen_reg <= '0;
                    for (int i = 0; i < 3; i++)
                        for (int a = 0; a < 3; a++)
                            win_reg[i][a] <= '0;
                end
                else
                begin
                    if (seen_reg != 2'd3)
                        seen_reg <= seen_reg + 2'd1;
                    for (int a = 0; a < 3; a++)
                    begin
                        win_reg[0][a] <= win_reg[1][a];
                        win_reg[1][a] <= win_reg[2][a];
                        win_reg[2][a] <= pin_reg[a];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pin_reg[0] <= point_x;
            pin_reg[1] <= point_y;
            pin_reg[2] <= point_z;
            last_reg   <= last_point;
            two_reg    <= last_point && seen_reg >= 2'd2;
            seg_reg    <= 1'b0;
            ax_reg     <= 2'd0;
            j_reg      <= '0;
            k_reg      <= k_eff;
            step_reg   <= step_q;
            t_reg      <= '0;
        end
        if (st_reg == ST_COEF)
        begin
            ca_reg <= (q0 <<< 1) - (q1 <<< 1) + s0 + s1;
            cb_reg <= (q1 - q0) * AW'(3) - (s0 <<< 1) - s1;
            cc_reg <= s0;
            cd_reg <= q0;
        end
        if (st_reg == ST_ACC && ev_done)
        begin
            res_reg[ax_reg] <= ev_res;
            if (ax_reg != 2'd2)
                ax_reg <= ax_reg + 2'd1;
        end
        if (st_reg == ST_OUT && (!ov_reg || out_ready))
        begin
            curve_x     <= res_reg[0];
            curve_y     <= res_reg[1];
            curve_z     <= res_reg[2];
            ls_reg      <= all_end;
            ax_reg      <= 2'd0;
            if (seg_end)
            begin
                j_reg   <= '0;
                t_reg   <= '0;
                seg_reg <= 1'b1;
            end
            else
            begin
                j_reg <= j_reg + KW'(1);
                t_reg <= t_reg + step_reg;
            end
        end
    end

    assign out_valid   = ov_reg;
    assign last_sample = ls_reg;
endmodule

// File: sv/crr_eval.sv
// horner evaluator for one axis sample on a shared multiplier
`timescale 1ns / 1ps
module crr_eval #(
    parameter int CW = 32,
    parameter int FB = 16,
    parameter int AW = 56
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [AW-1:0] coef_a,
    input  logic signed [AW-1:0] coef_b,
    input  logic signed [AW-1:0] coef_c,
    input  logic signed [AW-1:0] coef_d,
    input  logic        [FB:0]   t,
    output logic                 done,
    output logic        [CW-1:0] result
);
    import crr_pkg::*;

    localparam int PW = AW + FB + 2;
    localparam logic signed [AW-1:0] HI =
        AW'(signed'({1'b0, {(CW-1){1'b1}}}));
    localparam logic signed [AW-1:0] LO = -HI - AW'(1);

    logic [1:0]           step_reg, step_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic                 phase_reg, phase_next;
    logic [CW-1:0]        res_reg, res_next;
    logic signed [AW-1:0] addend;
    logic signed [AW-1:0] shifted;
    logic signed [AW-1:0] sum;

    always_comb
    begin
        unique case (step_reg)
            2'd0:    addend = coef_b;
            2'd1:    addend = coef_c;
            default: addend = coef_d;
        endcase
        // arithmetic shift floors
        shifted = AW'(prod_reg >>> FB);
        sum     = shifted + addend;
    end

    always_comb
    begin
        step_next  = step_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        acc_next   = acc_reg;
        prod_next  = prod_reg;
        phase_next = phase_reg;
        res_next   = res_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            step_next  = 2'd0;
            acc_next   = coef_a;
            phase_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                prod_next  = PW'(acc_reg) * PW'(signed'({1'b0, t}));
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                acc_next   = sum;
                if (step_reg == 2'd2)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    if (sum > HI)
                        res_next = HI[CW-1:0];
                    else if (sum < LO)
                        res_next = LO[CW-1:0];
                    else
                        res_next = sum[CW-1:0];
                end
                else
                    step_next = step_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule

// File: sv/crr_checker.sv
// port-level checker for the curve resampler, bound to the top level
`timescale 1ns / 1ps
module crr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] curve_x,
    input logic [31:0] curve_y,
    input logic [31:0] curve_z,
    input logic        last_sample
);
    // output payload holds while stalled
    a_out_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable({curve_x, curve_y, curve_z}))
        else $error("output payload changed while stalled");

    // after a point is taken the block is busy in the cycle after the accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready right after accept");

    // output word holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(last_sample)))
        else $error("output dropped while stalled");
endmodule

bind catmull_rom_curve_resampler_top crr_checker u_crr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .curve_x     (curve_x),
    .curve_y     (curve_y),
    .curve_z     (curve_z),
    .last_sample (last_sample)
);

// File: tb/tb_top.sv
// self-checking testbench for the catmull-rom curve resampler
`timescale 1ns / 1ps
module tb_top;
    import crr_pkg::*;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
    } point_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               last;
    } sample_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [CFG_ADDR_W+1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic in_valid, in_ready;
    logic signed [31:0] point_x, point_y, point_z;
    logic last_point;
    logic out_valid, out_ready;
    logic signed [31:0] curve_x, curve_y, curve_z;
    logic last_sample;

    catmull_rom_curve_resampler_top DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .last_point(last_point),
        .out_valid(out_valid), .out_ready(out_ready),
        .curve_x(curve_x), .curve_y(curve_y), .curve_z(curve_z),
        .last_sample(last_sample)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    point_t  pending_points[$];
    sample_t expected_samples[$];
    int errors = 0;

    // predictor state
    longint win_x[3], win_y[3], win_z[3];
    int     held_points = 0;
    int     samples_per_seg = 8;

    bit driver_calm = 0;
    bit sender_pause = 0;
    int hold_off_cycles = 0;
    bit receiver_calm = 0;

    function automatic longint half_down(longint v);
        return v >>> 1;
    endfunction

    function automatic longint frac_mul(longint a, longint t);
        return (a * t) >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint horner(longint p0, longint p1, longint t0, longint t1,
                                      longint t);
        longint a, b;
        a = 2 * p0 - 2 * p1 + t0 + t1;
        b = -3 * p0 + 3 * p1 - 2 * t0 - t1;
        return frac_mul(frac_mul(frac_mul(a, t) + b, t) + t0, t) + p0;
    endfunction

    task automatic push_segment(longint p0[3], longint p1[3], longint t0[3],
                                longint t1[3]);
        longint step;
        longint t;
        sample_t s;
        step = 65536 / samples_per_seg;
        for (int j = 0; j < samples_per_seg; j++)
        begin
            t = j * step;
            s.x = clamp32(horner(p0[0], p1[0], t0[0], t1[0], t));
            s.y = clamp32(horner(p0[1], p1[1], t0[1], t1[1], t));
            s.z = clamp32(horner(p0[2], p1[2], t0[2], t1[2], t));
            s.last = 1'b0;
            expected_samples = {expected_samples, s};
        end
    endtask

    task automatic predict_samples(point_t pt);
        longint q0[3], q1[3], q2[3], q3[3], ta[3], tb[3], tc[3];
        int before_cnt;
        before_cnt = expected_samples.size();
        q0 = '{win_x[0], win_y[0], win_z[0]};
        q1 = '{win_x[1], win_y[1], win_z[1]};
        q2 = '{win_x[2], win_y[2], win_z[2]};
        q3 = '{longint'(pt.x), longint'(pt.y), longint'(pt.z)};
        if (held_points == 1 && pt.last)
        begin
            for (int a = 0; a < 3; a++)
                ta[a] = q3[a] - q2[a];
            push_segment(q2, q3, ta, ta);
        end
        else if (held_points >= 2)
        begin
            for (int a = 0; a < 3; a++)
            begin
                ta[a] = (held_points == 2) ? q2[a] - q1[a] : half_down(q2[a] - q0[a]);
                tb[a] = half_down(q3[a] - q1[a]);
                tc[a] = q3[a] - q2[a];
            end
            push_segment(q1, q2, ta, tb);
            if (pt.last)
                push_segment(q2, q3, tb, tc);
        end
        if (expected_samples.size() > before_cnt)
            expected_samples[$].last = 1'b1;
        if (pt.last)
        begin
            win_x = '{0, 0, 0};
            win_y = '{0, 0, 0};
            win_z = '{0, 0, 0};
            held_points = 0;
        end
        else
        begin
            win_x = '{q1[0], q2[0], q3[0]};
            win_y = '{q1[1], q2[1], q3[1]};
            win_z = '{q1[2], q2[2], q3[2]};
            if (held_points < 3)
                held_points++;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            predict_samples(pending_points.pop_front());
        if (!in_valid || in_ready)
        begin
            if (pending_points.size() > 0
                && !sender_pause && (driver_calm || $urandom_range(99) >= 33))
            begin
                point_t nx;
                nx = pending_points[0];
                in_valid <= 1'b1;
                point_x <= nx.x;
                point_y <= nx.y;
                point_z <= nx.z;
                last_point <= nx.last;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            sample_t e;
            if (expected_samples.size() == 0)
            begin
                $error("unexpected sample x=%0d y=%0d z=%0d", curve_x, curve_y, curve_z);
                errors++;
            end
            else
            begin
                e = expected_samples.pop_front();
                if (curve_x !== e.x)
                begin
                    $error("curve_x expected %0d actual %0d", e.x, curve_x);
                    errors++;
                end
                if (curve_y !== e.y)
                begin
                    $error("curve_y expected %0d actual %0d", e.y, curve_y);
                    errors++;
                end
                if (curve_z !== e.z)
                begin
                    $error("curve_z expected %0d actual %0d", e.z, curve_z);
                    errors++;
                end
                if (last_sample !== e.last)
                begin
                    $error("last_sample expected %0d actual %0d", e.last, last_sample);
                    errors++;
                end
            end
        end
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= receiver_calm || ($urandom_range(99) >= 33);
    end

    task automatic write_k(int value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {REG_PPS, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (value == 0)
            samples_per_seg = 1;
        else if ((value & 31) > 16)
            samples_per_seg = 16;
        else
            samples_per_seg = value & 31;
    endtask

    task automatic drain();
        while (pending_points.size() > 0 || in_valid || expected_samples.size() > 0)
            @(posedge clk);
        repeat (800) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'sh7fffffff - $urandom_range(3);
            1: return 32'sh80000000 + $urandom_range(3);
            2: return $urandom;
            default: return $signed($urandom_range(65536 * 200)) - 32'sd6553600;
        endcase
    endfunction

    task automatic add_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic lst);
        point_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.last = lst;
        pending_points = {pending_points, p};
    endtask

    task automatic random_curves(int count);
        int n;
        while (count > 0)
        begin
            n = $urandom_range(3) == 0 ? $urandom_range(1, 2) : $urandom_range(3, 8);
            for (int i = 0; i < n; i++)
                add_point(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
            count -= n;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        point_x = '0;
        point_y = '0;
        point_z = '0;
        last_point = 1'b0;
        out_ready = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: lone point, two-point curve, extremes, long curve
        add_point(32'sd65536, -32'sd65536, 32'sd0, 1'b1);
        add_point(32'sd0, 32'sd0, 32'sd0, 1'b0);
        add_point(32'sd131072, 32'sd65536, -32'sd65536, 1'b1);
        add_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b0);
        add_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0);
        add_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b0);
        add_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b1);
        add_point(-32'sd1, -32'sd1, -32'sd1, 1'b0);
        add_point(32'sd1, 32'sd3, -32'sd5, 1'b0);
        add_point(32'sd655360, -32'sd327680, 32'sd98304, 1'b0);
        add_point(32'shffff0000, 32'sh0000ffff, 32'sh55555555, 1'b0);
        add_point(32'shaaaaaaaa, 32'sh12345678, 32'shedcba987, 1'b1);
        drain();

        write_k(1);
        random_curves(20);
        drain();
        write_k(16);
        // receiver holds off while the sender keeps offering
        hold_off_cycles = 600;
        random_curves(20);
        drain();
        write_k(0);
        random_curves(20);
        drain();
        write_k(31);
        random_curves(10);
        drain();
        write_k(3);
        driver_calm = 1;
        receiver_calm = 1;
        random_curves(40);
        drain();
        driver_calm = 0;
        receiver_calm = 0;
        write_k(8);
        random_curves(30);
        // sender waits for everything outstanding
        while (pending_points.size() > 0 || in_valid)
            @(posedge clk);
        sender_pause = 1;
        while (expected_samples.size() > 0)
            @(posedge clk);
        sender_pause = 0;
        random_curves(30);
        drain();
        write_k($urandom_range(2, 15));
        random_curves(20);
        drain();

        if (errors == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_top NOT OK");
        $finish;
    end
endmodule

// File: catmull_rom_curve_resampler_top.f
sv/crr_pkg.sv
sv/crr_eval.sv
sv/catmull_rom_curve_resampler_top.sv
sv/crr_checker.sv
tb/tb_top.sv
